// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== sv/svm_pkg.sv =====
// ----------------------------------------------------------------------------
// svm_pkg
// Shared constants and types of the sample voice mixer.
// ----------------------------------------------------------------------------
package svm_pkg;
	localparam int VOICES     = 8;
	localparam int VOICE_W    = 3;
	localparam int DESC_SLOTS = 64;
	localparam int DESC_W     = 6;
	localparam int MEM_AW     = 16;
	localparam int RAMP_LEN   = 64;
	localparam int RAMP_STEP  = 32768 / RAMP_LEN;

	localparam logic [2:0] OP_WRITE = 3'd0;
	localparam logic [2:0] OP_DESC  = 3'd1;
	localparam logic [2:0] OP_START = 3'd2;
	localparam logic [2:0] OP_FADE  = 3'd3;
	localparam logic [2:0] OP_TICK  = 3'd4;

	localparam logic [1:0] CFG_IN_USE = 2'd0;
	localparam logic [1:0] CFG_RAMP   = 2'd1;
	localparam logic [1:0] CFG_DECAY  = 2'd2;
	localparam logic [1:0] CFG_FADE   = 2'd3;

	// voice state word: sample id, position, gain
	typedef struct packed {
		logic [7:0]         id;
		logic [16:0]        pos;
		logic signed [15:0] gain;
	} voice_t;
endpackage

// ===== sv/sample_voice_mixer.sv =====
// ----------------------------------------------------------------------------
// sample_voice_mixer
// Sample-playback mixer: voices read sample memory, scale, ramp and sum.
// ----------------------------------------------------------------------------
// Write, descriptor, start and fade words are taken while idle; busy stays low.
// A tick keeps busy high while the voices are handled one at a time: a voice
// that is idle or stops passes the voice memory read and the descriptor read,
// a voice that plays also the sample memory read, the multiplies and the ramp;
// the result strobe rises as busy falls and the receiver cannot stall. Reset
// sets the state and control registers to defaults and clears descriptor valid bits.
module sample_voice_mixer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [2:0]              operation,
	input  logic [2:0]              voice,
	input  logic [7:0]              slot_id,
	input  logic [15:0]             address,
	input  logic signed [15:0]      sample_value,
	input  logic [16:0]             length,
	input  logic signed [15:0]      gain,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [14:0]             cfg_data,
	output logic                    valid,
	output logic signed [15:0]      mixed_sample,
	output logic [7:0]              active_voices
);
	import svm_pkg::*;
	`include "assert_macros.svh"

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_VRD  = 3'd1;
	localparam logic [2:0] ST_DRD  = 3'd2;
	localparam logic [2:0] ST_MRD  = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_RAMP = 3'd5;

	logic [2:0]  state_q;
	logic [VOICE_W-1:0] vidx_q;
	logic [VOICES-1:0]  active_q;
	logic [VOICES-1:0]  fading_q;
	logic [DESC_SLOTS-1:0] dvalid_q;
	logic [6:0]  in_use_q;
	logic        ramp_en_q, decay_en_q;
	logic [14:0] fade_q;
	logic signed [19:0] acc_q;

	logic        acc_op;
	assign acc_op = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	logic        voice_ok;
	assign voice_ok = {1'b0, voice} < 4'(VOICES);

	// voice memory
	voice_t vm_rdata, vm_wdata;
	logic   vm_we;
	logic [VOICE_W-1:0] vm_waddr;
	logic [VOICE_W-1:0] vm_raddr;
	svm_ram #(.WIDTH($bits(voice_t)), .DEPTH(VOICES)) u_vmem (
		.clk(clk), .we(vm_we), .waddr(vm_waddr), .wdata(vm_wdata),
		.raddr(vm_raddr), .rdata(vm_rdata));

	// descriptor memory: base and length
	logic [32:0] dm_rdata;
	logic        dm_we;
	svm_ram #(.WIDTH(33), .DEPTH(DESC_SLOTS)) u_dmem (
		.clk(clk), .we(dm_we), .waddr(slot_id[DESC_W-1:0]),
		.wdata({address, length}), .raddr(vm_rdata.id[DESC_W-1:0]),
		.rdata(dm_rdata));

	// sample memory
	logic [15:0] sm_rdata, sm_raddr;
	logic        sm_we;
	svm_ram #(.WIDTH(16), .DEPTH(1 << MEM_AW)) u_smem (
		.clk(clk), .we(sm_we), .waddr(address), .wdata(sample_value),
		.raddr(sm_raddr), .rdata(sm_rdata));

	// latched voice and descriptor values
	voice_t v_s1;
	logic [16:0] len_s2;
	logic [16:0] pos_s2;
	logic        dval_s2;
	logic signed [31:0] prod_s3;
	logic        ramp_hit_s3;
	logic [17:0] rampk_s3;
	logic signed [15:0] newgain_s3;

	logic id_ok;
	assign id_ok = ({1'b0, v_s1.id} < {2'b0, in_use_q}) && (v_s1.id < 8'(DESC_SLOTS));
	logic [16:0] dlen;
	assign dlen = dvalid_q[v_s1.id[DESC_W-1:0]] ? dm_rdata[16:0] : 17'd0;
	logic [15:0] dbase;
	assign dbase = dvalid_q[v_s1.id[DESC_W-1:0]] ? dm_rdata[32:17] : 16'd0;
	assign sm_raddr = dbase + v_s1.pos[15:0];

	logic play;
	assign play = id_ok && (dlen != 17'd0) && (v_s1.pos < dlen);

	// address the next voice as the current one leaves
	logic adv;
	assign adv = (state_q == ST_RAMP) ||
		(state_q == ST_DRD && !(active_q[vidx_q] && play));
	assign vm_raddr = adv ? vidx_q + VOICE_W'(1) : vidx_q;

	logic [16:0] rstart;
	assign rstart = (dlen > 17'(RAMP_LEN)) ? dlen - 17'(RAMP_LEN) : 17'd0;

	// gain decay product
	logic signed [31:0] gprod;
	assign gprod = v_s1.gain * $signed({1'b0, fade_q});

	// ramp product
	logic signed [35:0] rprod;
	assign rprod = $signed(prod_s3[31:15]) * $signed({1'b0, rampk_s3});

	logic signed [16:0] contrib;
	always_comb begin
		contrib = prod_s3[31:15];
		if (ramp_hit_s3) begin
			contrib = 17'(rprod >>> 15);
		end
	end

	// voice write back and fills
	always_comb begin
		vm_we    = 1'b0;
		vm_waddr = vidx_q;
		vm_wdata = v_s1;
		if (state_q == ST_IDLE && acc_op && voice_ok) begin
			if (operation == OP_START) begin
				vm_we = 1'b1;
				vm_waddr = voice;
				vm_wdata = '{id: slot_id, pos: 17'd0, gain: gain};
			end
		end else if (state_q == ST_RAMP) begin
			vm_we = 1'b1;
			vm_wdata.pos  = pos_s2 + 17'd1;
			vm_wdata.gain = newgain_s3;
		end
	end
	assign dm_we = acc_op && operation == OP_DESC && slot_id < 8'(DESC_SLOTS);
	assign sm_we = acc_op && operation == OP_WRITE;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vidx_q     <= '0;
			active_q   <= '0;
			dvalid_q   <= '0;
			in_use_q   <= '0;
			ramp_en_q  <= 1'b1;
			decay_en_q <= 1'b1;
			fade_q     <= 15'd32604;
			acc_q      <= '0;
			valid      <= 1'b0;
			fading_q   <= '0;
		end else begin
			valid <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_IN_USE: in_use_q   <= cfg_data[6:0];
					CFG_RAMP:   ramp_en_q  <= cfg_data[0];
					CFG_DECAY:  decay_en_q <= cfg_data[0];
					CFG_FADE:   fade_q     <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_op) begin
						if (operation == OP_DESC && slot_id < 8'(DESC_SLOTS))
							dvalid_q[slot_id[DESC_W-1:0]] <= 1'b1;
						if (operation == OP_START && voice_ok) begin
							active_q[voice] <= 1'b1;
							fading_q[voice] <= 1'b0;
						end
						if (operation == OP_FADE && voice_ok)
							fading_q[voice] <= 1'b1;
						if (operation == OP_TICK) begin
							state_q <= ST_VRD;
							vidx_q  <= '0;
							acc_q   <= '0;
						end
					end
				end
				ST_VRD: state_q <= ST_DRD;
				ST_DRD: begin
					if (active_q[vidx_q] && play) begin
						state_q <= ST_MRD;
					end else begin
						if (active_q[vidx_q])
							active_q[vidx_q] <= 1'b0;
						state_q <= ST_VRD;
						if (vidx_q == VOICE_W'(VOICES - 1)) begin
							state_q <= ST_IDLE;
							valid   <= 1'b1;
						end
						vidx_q <= vidx_q + 1'b1;
					end
				end
				ST_MRD: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_RAMP;
				ST_RAMP: begin
					acc_q <= acc_q + 20'(contrib);
					if (decay_en_q && fading_q[vidx_q] && newgain_s3 == 16'sd0)
						active_q[vidx_q] <= 1'b0;
					state_q <= ST_VRD;
					if (vidx_q == VOICE_W'(VOICES - 1)) begin
						state_q <= ST_IDLE;
						valid   <= 1'b1;
					end
					vidx_q <= vidx_q + 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_DRD) begin
			len_s2  <= dlen;
			pos_s2  <= v_s1.pos;
			dval_s2 <= ramp_en_q && (v_s1.pos >= rstart);
			newgain_s3 <= (decay_en_q && fading_q[vidx_q]) ? 16'(gprod >>> 15) : v_s1.gain;
		end
		if (state_q == ST_MUL) begin
			prod_s3     <= $signed(sm_rdata) * v_s1.gain;
			ramp_hit_s3 <= dval_s2;
			rampk_s3    <= 18'((len_s2 - pos_s2) * RAMP_STEP);
		end
		if (state_q == ST_VRD) begin
			v_s1 <= vm_rdata;
		end
	end

	// output saturation
	always_comb begin
		if (acc_q > 20'sd32767)
			mixed_sample = 16'sh7FFF;
		else if (acc_q < -20'sd32768)
			mixed_sample = 16'sh8000;
		else
			mixed_sample = acc_q[15:0];
	end
	assign active_voices = 8'(active_q);

	`ASSERT_IMPLY(a_busy_tick, clk, arst_n, valid, !busy)
	`ASSERT_NEXT(a_tick_starts, clk, arst_n, acc_op && operation == OP_TICK, busy)
	`ASSERT_IMPLY(a_no_write_busy, clk, arst_n, busy, !sm_we && !dm_we)
endmodule

// ===== sv/svm_ram.sv =====
// ----------------------------------------------------------------------------
// svm_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
module svm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
